@@ hw/rtl/ialucc_pkg.sv @@
// ----------------------------------------------------------------------------
// ialucc_pkg
// Shared types and constants of the immediate ALU with condition codes:
// channel item layouts, operation codes, and the decoded micro-op that
// travels from the front part to the back part.
// ----------------------------------------------------------------------------
`default_nettype none

package ialucc_pkg;

  // Operation codes of the mode field.
  localparam logic [3:0] MODE_OR      = 4'd0;
  localparam logic [3:0] MODE_AND     = 4'd1;
  localparam logic [3:0] MODE_SUB     = 4'd2;
  localparam logic [3:0] MODE_ADD     = 4'd3;
  localparam logic [3:0] MODE_EOR     = 4'd4;
  localparam logic [3:0] MODE_CMP     = 4'd5;
  localparam logic [3:0] MODE_BTST    = 4'd6;
  localparam logic [3:0] MODE_BCLR    = 4'd7;
  localparam logic [3:0] MODE_BSET    = 4'd8;
  localparam logic [3:0] MODE_OR_CCR  = 4'd9;
  localparam logic [3:0] MODE_AND_CCR = 4'd10;
  localparam logic [3:0] MODE_OR_SR   = 4'd11;
  localparam logic [3:0] MODE_AND_SR  = 4'd12;

  // Operand size codes. Code three behaves as a long word.
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_WORD = 2'd1;

  // Bit positions inside the five condition-code bits.
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_V = 1;
  localparam int unsigned FLAG_Z = 2;
  localparam int unsigned FLAG_N = 3;
  localparam int unsigned FLAG_X = 4;

  // System byte after reset: supervisor state, interrupt mask seven.
  localparam logic [7:0] SYS_RESET    = 8'h27;
  localparam int unsigned SYS_SUPER   = 5;

  typedef struct packed {
    logic [3:0]  mode;
    logic [1:0]  size;
    logic [31:0] dest_value;
    logic [31:0] immediate;
    logic [7:0]  bit_number;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic        write_back;
    logic [4:0]  flags_out;
    logic [15:0] status_out;
    logic        privilege_fault;
  } out_item_t;

  // How the back part merges a micro-op into the status state.
  typedef enum logic [2:0] {
    KIND_NOP,      // no state change
    KIND_KEEPX,    // take N Z V C, keep X (logic ops and compare)
    KIND_ARITH,    // take all five flags (add and subtract)
    KIND_BIT,      // take Z only
    KIND_OR_CCR,
    KIND_AND_CCR,
    KIND_OR_SR,
    KIND_AND_SR
  } uop_kind_t;

  typedef struct packed {
    uop_kind_t   kind;
    logic [31:0] result_value;
    logic        write_back;
    logic [4:0]  flags;
    logic [15:0] imm;
  } uop_t;

endpackage

`default_nettype wire

@@ hw/rtl/ialucc_front.sv @@
// ----------------------------------------------------------------------------
// ialucc_front
// Front part: accepts items and computes everything that does not depend on
// the status state (result value, candidate flags, merge kind).
// ----------------------------------------------------------------------------
`default_nettype none

module ialucc_front (
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire ialucc_pkg::in_item_t in_item,
  input  wire logic                 q_full,
  output logic                      push,
  output ialucc_pkg::uop_t          push_uop
);
  import ialucc_pkg::*;

  logic [31:0] mask;
  logic [31:0] sign_m;
  logic [4:0]  bidx;
  logic [31:0] a;
  logic [31:0] b;
  logic [32:0] sum;
  logic [32:0] dif;
  logic [31:0] sum_r;
  logic [31:0] dif_r;
  logic        carry;
  logic        borrow;
  logic [31:0] bm;
  logic [31:0] logic_r;

  function automatic logic [1:0] nz_of(input logic [31:0] v, input logic [31:0] sm);
    nz_of = {|(v & sm), (v == 32'd0)};
  endfunction

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    case (in_item.size)
      SIZE_BYTE: begin
        mask   = 32'h0000_00ff;
        sign_m = 32'h0000_0080;
        bidx   = {2'b00, in_item.bit_number[2:0]};
      end
      SIZE_WORD: begin
        mask   = 32'h0000_ffff;
        sign_m = 32'h0000_8000;
        bidx   = {1'b0, in_item.bit_number[3:0]};
      end
      default: begin
        mask   = 32'hffff_ffff;
        sign_m = 32'h8000_0000;
        bidx   = in_item.bit_number[4:0];
      end
    endcase
  end

  always_comb begin
    a      = in_item.dest_value & mask;
    b      = in_item.immediate & mask;
    sum    = {1'b0, a} + {1'b0, b};
    dif    = {1'b0, a} - {1'b0, b};
    sum_r  = sum[31:0] & mask;
    dif_r  = dif[31:0] & mask;
    // Both operands are zero-extended, so bit 32 of the difference is the borrow.
    borrow = dif[32];
    case (in_item.size)
      SIZE_BYTE: carry = sum[8];
      SIZE_WORD: carry = sum[16];
      default:   carry = sum[32];
    endcase
    bm = 32'd1 << bidx;
    case (in_item.mode)
      MODE_OR:  logic_r = a | b;
      MODE_AND: logic_r = a & b;
      default:  logic_r = a ^ b;
    endcase
  end

  always_comb begin
    push_uop.kind         = KIND_NOP;
    push_uop.result_value = 32'd0;
    push_uop.write_back   = 1'b0;
    push_uop.flags        = 5'd0;
    push_uop.imm          = in_item.immediate[15:0];
    case (in_item.mode)
      MODE_OR, MODE_AND, MODE_EOR: begin
        push_uop.kind         = KIND_KEEPX;
        push_uop.result_value = logic_r;
        push_uop.write_back   = 1'b1;
        push_uop.flags        = {1'b0, nz_of(logic_r, sign_m), 2'b00};
      end
      MODE_ADD: begin
        push_uop.kind         = KIND_ARITH;
        push_uop.result_value = sum_r;
        push_uop.write_back   = 1'b1;
        push_uop.flags        = {carry, nz_of(sum_r, sign_m),
                                 |((a ^ sum_r) & (b ^ sum_r) & sign_m), carry};
      end
      MODE_SUB: begin
        push_uop.kind         = KIND_ARITH;
        push_uop.result_value = dif_r;
        push_uop.write_back   = 1'b1;
        push_uop.flags        = {borrow, nz_of(dif_r, sign_m),
                                 |((a ^ b) & (a ^ dif_r) & sign_m), borrow};
      end
      MODE_CMP: begin
        push_uop.kind  = KIND_KEEPX;
        push_uop.flags = {1'b0, nz_of(dif_r, sign_m),
                          |((a ^ b) & (a ^ dif_r) & sign_m), borrow};
      end
      MODE_BTST: begin
        push_uop.kind          = KIND_BIT;
        push_uop.flags[FLAG_Z] = !a[bidx];
      end
      MODE_BCLR: begin
        push_uop.kind          = KIND_BIT;
        push_uop.flags[FLAG_Z] = !a[bidx];
        push_uop.result_value  = a & ~bm & mask;
        push_uop.write_back    = 1'b1;
      end
      MODE_BSET: begin
        push_uop.kind          = KIND_BIT;
        push_uop.flags[FLAG_Z] = !a[bidx];
        push_uop.result_value  = (a | bm) & mask;
        push_uop.write_back    = 1'b1;
      end
      MODE_OR_CCR:  push_uop.kind = KIND_OR_CCR;
      MODE_AND_CCR: push_uop.kind = KIND_AND_CCR;
      MODE_OR_SR:   push_uop.kind = KIND_OR_SR;
      MODE_AND_SR:  push_uop.kind = KIND_AND_SR;
      default:      push_uop.kind = KIND_NOP;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/ialucc_queue.sv @@
// ----------------------------------------------------------------------------
// ialucc_queue
// Short first-in first-out queue of decoded micro-ops between the front and
// back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module ialucc_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire ialucc_pkg::uop_t  push_uop,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output ialucc_pkg::uop_t       head_uop
);
  import ialucc_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  uop_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r;
  logic [PW-1:0] rd_ptr_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          do_push;
  logic          do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_uop   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_uop;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ialucc_back.sv @@
// ----------------------------------------------------------------------------
// ialucc_back
// Back part: holds the condition codes and system byte, merges each micro-op
// into them and presents the result item from an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ialucc_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              head_valid,
  input  wire ialucc_pkg::uop_t  head_uop,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ialucc_pkg::out_item_t  out_item
);
  import ialucc_pkg::*;

  logic [4:0] flags_r;
  logic [4:0] flags_nxt;
  logic [7:0] sys_r;
  logic [7:0] sys_nxt;
  logic       fault;
  logic       out_valid_r;
  logic       out_valid_nxt;
  out_item_t  out_item_r;
  out_item_t  out_item_nxt;

  assign pop       = head_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    flags_nxt = flags_r;
    sys_nxt   = sys_r;
    fault     = 1'b0;
    case (head_uop.kind)
      KIND_KEEPX: flags_nxt = {flags_r[FLAG_X], head_uop.flags[3:0]};
      KIND_ARITH: flags_nxt = head_uop.flags;
      KIND_BIT: begin
        flags_nxt         = flags_r;
        flags_nxt[FLAG_Z] = head_uop.flags[FLAG_Z];
      end
      KIND_OR_CCR:  flags_nxt = flags_r | head_uop.imm[4:0];
      KIND_AND_CCR: flags_nxt = flags_r & head_uop.imm[4:0];
      KIND_OR_SR, KIND_AND_SR: begin
        if (!sys_r[SYS_SUPER]) begin
          fault = 1'b1;
        end else if (head_uop.kind == KIND_OR_SR) begin
          sys_nxt   = sys_r | head_uop.imm[15:8];
          flags_nxt = flags_r | head_uop.imm[4:0];
        end else begin
          sys_nxt   = sys_r & head_uop.imm[15:8];
          flags_nxt = flags_r & head_uop.imm[4:0];
        end
      end
      default: begin
        flags_nxt = flags_r;
      end
    endcase
    out_item_nxt.result_value    = head_uop.result_value;
    out_item_nxt.write_back      = head_uop.write_back;
    out_item_nxt.flags_out       = flags_nxt;
    out_item_nxt.status_out      = {sys_nxt, 3'b000, flags_nxt};
    out_item_nxt.privilege_fault = fault;
    out_valid_nxt = pop ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      flags_r     <= 5'd0;
      sys_r       <= SYS_RESET;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        flags_r <= flags_nxt;
        sys_r   <= sys_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/immediate_alu_with_condition_codes.sv @@
// ----------------------------------------------------------------------------
// immediate_alu_with_condition_codes
// Execute unit for immediate-group instructions with condition codes and
// the system byte of the status register.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while in_stall is low and returns
// one result item per item, in order. An accepted item is decoded at once and
// written into the queue; the back part then merges it and registers its
// result in the output register that drives the output channel. The sustained
// rate of one item per cycle, while the output is not stalled, is set by the
// back part, which merges each decoded operation into the condition codes and system byte.
// A queue of QUEUE_DEPTH decoded operations sits between the decoder and the
// back part; in_stall rises only when that queue is full, which happens when
// out_stall holds off results while items keep arriving back to back. The
// block keeps the condition codes (X N Z V C) and the system byte, which
// reset to zero and to supervisor state with interrupt mask seven.
// Status-register operations in user state report a privilege fault and
// leave the state unchanged.
`default_nettype none

module immediate_alu_with_condition_codes #(
  // Number of decoded items that can wait between decode and execute.
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire ialucc_pkg::in_item_t in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output ialucc_pkg::out_item_t     out_item
);
  import ialucc_pkg::*;

  // Decoded operations flowing from the front part into the queue.
  logic push;
  uop_t push_uop;
  logic q_full;

  // Head of the queue, consumed by the back part.
  logic head_valid;
  uop_t head_uop;
  logic pop;

  // The front part computes the result value and the candidate flags, which
  // depend only on the item itself.
  ialucc_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .push     (push),
    .push_uop (push_uop)
  );

  // The queue lets the input side keep accepting items while a result is
  // waiting to be taken on the output side.
  ialucc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_uop   (push_uop),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_uop   (head_uop)
  );

  // The back part owns the status state and the output register.
  ialucc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_uop   (head_uop),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item)
  );

`ifndef NO_ASSERTIONS
  // A refused status-register operation never asks for a write-back.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.privilege_fault && out_item.write_back))
    else $error("privilege fault reported together with write-back");

  // A privilege fault can only come from user state, and since the state is
  // left unchanged the reported status must still show user state.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.privilege_fault) |-> !out_item.status_out[8 + SYS_SUPER])
    else $error("privilege fault reported in supervisor state");

  // The low byte of the status carries the same condition codes as flags_out
  // and its unimplemented bits read as zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status_out[4:0] == out_item.flags_out) &&
                  (out_item.status_out[7:5] == 3'b000))
    else $error("status low byte does not match condition codes");

  // Items without write-back return a zero result value.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.write_back) |-> (out_item.result_value == 32'd0))
    else $error("nonzero result value without write-back");
`endif

endmodule

`default_nettype wire

@@ tb/ialucc_tb_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ialucc_tb_pkg
// Scoreboard for the immediate ALU: it tracks the condition codes and the
// system byte, predicts one result per accepted item, and checks results in
// order.
// ----------------------------------------------------------------------------

package ialucc_tb_pkg;

  import ialucc_pkg::*;

  class immediate_alu_checker;

    logic [4:0]  ccr;
    logic [7:0]  sys_byte;
    out_item_t   expected_results[$];
    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned items_noted;

    function new();
      ccr             = '0;
      sys_byte        = SYS_RESET;
      mismatches      = 0;
      results_checked = 0;
      items_noted     = 0;
    endfunction

    // N and Z of a result at the current operand size.
    function logic [4:0] sign_zero_flags(logic [31:0] r, logic [31:0] sign);
      logic [4:0] f;
      f         = '0;
      f[FLAG_N] = (r & sign) != 0;
      f[FLAG_Z] = (r == 0);
      return f;
    endfunction

    // Executes one instruction on the tracked status and returns its result.
    function out_item_t execute_immediate(in_item_t it);
      int unsigned bits;
      logic [31:0] mask, sign, a, b, r, d, bm;
      logic [32:0] sum;
      logic [15:0] sr;
      logic [4:0]  f, nf;
      logic        wb, fault;
      out_item_t   res;
      case (it.size)
        SIZE_BYTE: begin bits = 8;  mask = 32'h0000_00ff; end
        SIZE_WORD: begin bits = 16; mask = 32'h0000_ffff; end
        default:   begin bits = 32; mask = 32'hffff_ffff; end
      endcase
      sign  = 32'h1 << (bits - 1);
      a     = it.dest_value & mask;
      b     = it.immediate & mask;
      bm    = 32'h1 << (it.bit_number & 8'(bits - 1));
      r     = '0;
      f     = ccr;
      wb    = 1'b0;
      fault = 1'b0;
      case (it.mode)
        MODE_OR, MODE_AND, MODE_EOR: begin
          if (it.mode == MODE_OR) r = a | b;
          else if (it.mode == MODE_AND) r = a & b;
          else r = a ^ b;
          nf         = sign_zero_flags(r, sign);
          nf[FLAG_X] = ccr[FLAG_X];
          f          = nf;
          wb         = 1'b1;
        end
        MODE_ADD: begin
          sum        = {1'b0, a} + {1'b0, b};
          r          = sum[31:0] & mask;
          f          = sign_zero_flags(r, sign);
          f[FLAG_V]  = ((a ^ r) & (b ^ r) & sign) != 0;
          f[FLAG_C]  = sum[bits];
          f[FLAG_X]  = sum[bits];
          wb         = 1'b1;
        end
        MODE_SUB, MODE_CMP: begin
          d          = (a - b) & mask;
          nf         = sign_zero_flags(d, sign);
          nf[FLAG_V] = ((a ^ b) & (a ^ d) & sign) != 0;
          nf[FLAG_C] = b > a;
          if (it.mode == MODE_SUB) begin
            nf[FLAG_X] = b > a;
            r          = d;
            wb         = 1'b1;
          end else begin
            nf[FLAG_X] = ccr[FLAG_X];
          end
          f = nf;
        end
        MODE_BTST, MODE_BCLR, MODE_BSET: begin
          f[FLAG_Z] = (a & bm) == 0;
          if (it.mode == MODE_BCLR) begin
            r  = a & ~bm & mask;
            wb = 1'b1;
          end else if (it.mode == MODE_BSET) begin
            r  = (a | bm) & mask;
            wb = 1'b1;
          end
        end
        MODE_OR_CCR:  f = ccr | it.immediate[4:0];
        MODE_AND_CCR: f = ccr & it.immediate[4:0];
        MODE_OR_SR, MODE_AND_SR: begin
          if (!sys_byte[SYS_SUPER]) begin
            fault = 1'b1;
          end else begin
            sr = {sys_byte, 3'b000, ccr};
            if (it.mode == MODE_OR_SR) sr = sr | it.immediate[15:0];
            else sr = sr & it.immediate[15:0];
            sys_byte = sr[15:8];
            f        = sr[4:0];
          end
        end
        default: ;
      endcase
      ccr                 = f;
      res.result_value    = wb ? (r & mask) : 32'h0;
      res.write_back      = wb;
      res.flags_out       = ccr;
      res.status_out      = {sys_byte, 3'b000, ccr};
      res.privilege_fault = fault;
      return res;
    endfunction

    function void note_input(in_item_t it);
      items_noted++;
      expected_results.push_back(execute_immediate(it));
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH result %0d: %s", results_checked, what);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      results_checked++;
      if (expected_results.size() == 0) begin
        report("result arrived with no item outstanding");
        return;
      end
      want = expected_results.pop_front();
      if (got.result_value !== want.result_value)
        report($sformatf("result_value %h, expected %h", got.result_value, want.result_value));
      if (got.write_back !== want.write_back)
        report($sformatf("write_back %b, expected %b", got.write_back, want.write_back));
      if (got.flags_out !== want.flags_out)
        report($sformatf("flags_out %b, expected %b", got.flags_out, want.flags_out));
      if (got.status_out !== want.status_out)
        report($sformatf("status_out %h, expected %h", got.status_out, want.status_out));
      if (got.privilege_fault !== want.privilege_fault)
        report($sformatf("privilege_fault %b, expected %b",
                         got.privilege_fault, want.privilege_fault));
    endtask

  endclass

endpackage

@@ tb/immediate_alu_with_condition_codes_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// immediate_alu_with_condition_codes_tb
// Self-checking bench for the immediate ALU with condition codes.
// ----------------------------------------------------------------------------
// A directed burst hits the flag corner cases of every operation, then random
// instruction streams run under four idling patterns while the status stays
// in supervisor state. A closing stretch drops to user state so that the
// privilege fault path is exercised. Every result is checked against a
// predictor that tracks the condition codes and the system byte.
// ----------------------------------------------------------------------------

module immediate_alu_with_condition_codes_tb;

  import ialucc_pkg::*;
  import ialucc_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  immediate_alu_checker sb;

  // Percentages that shape the handshakes: how often the sender sits idle
  // before an item and how often the receiver holds off a result.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_count;

  immediate_alu_with_condition_codes dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // The receiver stalls at random with the current percentage.
  always @(posedge clk) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Both monitors sample at the clock edge, before the block updates, so an
  // item counts exactly when valid is high and stall is low at that edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_input(in_item);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  // Presents one item, idling first at random, and returns at the edge that
  // accepts it. Valid stays high so back-to-back items need no extra NBA.
  task automatic send_item(input in_item_t it);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_fields(input logic [3:0] mode, input logic [1:0] size,
                             input logic [31:0] dest, input logic [31:0] imm,
                             input logic [7:0] bitn);
    in_item_t it;
    it.mode       = mode;
    it.size       = size;
    it.dest_value = dest;
    it.immediate  = imm;
    it.bit_number = bitn;
    send_item(it);
  endtask

  // Operands lean toward the values that flip carry, overflow and zero.
  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = 32'h0;
      1:       v = 32'hffff_ffff;
      2:       v = 32'h1 << $urandom_range(0, 31);
      3:       v = ~(32'h1 << $urandom_range(0, 31));
      4:       v = 32'($urandom_range(0, 3));
      5:       v = $urandom ^ (32'h1 << ($urandom_range(0, 3) * 8 + 7));
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // While supervisor state is to be kept, AND to SR always keeps the S bit,
  // since nothing can set it again once it is gone.
  function automatic in_item_t random_instruction(input bit keep_super);
    in_item_t it;
    if ($urandom_range(0, 99) < 8) it.mode = 4'($urandom_range(13, 15));
    else it.mode = 4'($urandom_range(0, 12));
    it.size       = 2'($urandom_range(0, 3));
    it.dest_value = pick_operand();
    it.immediate  = pick_operand();
    it.bit_number = 8'($urandom_range(0, 255));
    if (keep_super && it.mode == MODE_AND_SR) it.immediate[8 + SYS_SUPER] = 1'b1;
    return it;
  endfunction

  task automatic run_random(input int unsigned count, input int unsigned idle_pct,
                            input int unsigned stall_pct, input bit keep_super);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_item(random_instruction(keep_super));
  endtask

  initial begin
    sb             = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_item        = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Carry, overflow and zero at every size, with garbage
    // above the operand size to show it is masked off.
    send_fields(MODE_ADD, SIZE_BYTE, 32'hdead_beff, 32'h1234_5601, 8'd0);
    send_fields(MODE_ADD, SIZE_BYTE, 32'h0000_007f, 32'h0000_0001, 8'd0);
    send_fields(MODE_ADD, SIZE_WORD, 32'h0000_ffff, 32'hffff_ffff, 8'd0);
    // Size code three behaves as a long word.
    send_fields(MODE_ADD, 2'd3, 32'h7fff_ffff, 32'h0000_0001, 8'd0);
    send_fields(MODE_SUB, SIZE_BYTE, 32'h0000_0000, 32'h0000_0001, 8'd0);
    send_fields(MODE_SUB, 2'd2, 32'h8000_0000, 32'h0000_0001, 8'd0);
    // Compare sets the borrow in C but leaves X from the subtract above.
    send_fields(MODE_CMP, SIZE_WORD, 32'h0000_8000, 32'h0000_0001, 8'd0);
    send_fields(MODE_CMP, 2'd2, 32'h0000_0000, 32'hffff_ffff, 8'd0);
    send_fields(MODE_OR, SIZE_BYTE, 32'haaaa_aa55, 32'hffff_ff00, 8'd0);
    send_fields(MODE_AND, 2'd2, 32'hffff_ffff, 32'h0000_0000, 8'd0);
    send_fields(MODE_EOR, SIZE_WORD, 32'h1234_ffff, 32'h0000_ffff, 8'd0);
    // Bit numbers wrap modulo the operand width.
    send_fields(MODE_BTST, SIZE_BYTE, 32'h0000_0080, 32'h0, 8'd255);
    send_fields(MODE_BTST, 2'd2, 32'h0000_0000, 32'h0, 8'd31);
    send_fields(MODE_BCLR, SIZE_WORD, 32'hffff_ffff, 32'h0, 8'd17);
    send_fields(MODE_BSET, 2'd3, 32'h0000_0000, 32'h0, 8'd0);
    // CCR operations ignore the upper three bits of their byte.
    send_fields(MODE_OR_CCR, SIZE_BYTE, 32'h0, 32'hffff_ffff, 8'd0);
    send_fields(MODE_AND_CCR, SIZE_WORD, 32'h0, 32'h0000_00e0, 8'd0);
    send_fields(MODE_OR_CCR, 2'd2, 32'h0, 32'h0000_0015, 8'd0);
    // SR operations in supervisor state: bits 7..5 of the low byte vanish.
    send_fields(MODE_OR_SR, SIZE_BYTE, 32'h0, 32'h0000_ffff, 8'd0);
    send_fields(MODE_AND_SR, SIZE_BYTE, 32'h0, 32'h0000_2705, 8'd0);
    // Unused modes change nothing and write nothing back.
    send_fields(4'd13, SIZE_BYTE, 32'hffff_ffff, 32'hffff_ffff, 8'd255);
    send_fields(4'd14, SIZE_WORD, 32'h0, 32'h0, 8'd0);
    send_fields(4'd15, 2'd3, 32'h8000_0000, 32'h7fff_ffff, 8'd128);

    // Random part under the four idling patterns, supervisor state kept.
    run_random(200, 0, 0, 1'b1);
    run_random(200, 46, 0, 1'b1);
    run_random(200, 0, 46, 1'b1);
    run_random(200, 30, 30, 1'b1);

    // Drop to user state: from here every SR operation must fault.
    send_fields(MODE_AND_SR, SIZE_BYTE, 32'h0, 32'h0000_0000, 8'd0);
    send_fields(MODE_OR_SR, SIZE_WORD, 32'h0, 32'h0000_ffff, 8'd0);
    send_fields(MODE_AND_SR, 2'd2, 32'h0, 32'hffff_ffff, 8'd0);
    run_random(80, 20, 20, 1'b0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d items (directed corners, four idling patterns, user-state tail).",
             sb.items_noted);
    $display("Checked %0d results, %0d mismatches.", sb.results_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/ialucc_pkg.sv
hw/rtl/ialucc_front.sv
hw/rtl/ialucc_queue.sv
hw/rtl/ialucc_back.sv
hw/rtl/immediate_alu_with_condition_codes.sv
tb/ialucc_tb_pkg.sv
tb/immediate_alu_with_condition_codes_tb.sv
